[src/cts_pkg.sv]
// Shared constants, types and helpers for the fixed-point cosine pipeline.
package cts_pkg;

  localparam int TERMS_DEF = 99;
  localparam int FRAC_BITS = 30;
  localparam int ANGLE_W = 32;
  localparam int COS_W = 32;
  localparam int WIDEN_SH = 14;
  localparam int AMAG_W = 32;
  localparam int QEST_W = 14;
  localparam int RED_SHIFT = 32;
  localparam int TWO_PI_W = 33;
  localparam int REM_W = 34;
  localparam int RMAG_W = 33;
  localparam int X2_W = 36;
  localparam int MAG_W = 40;
  localparam int SUM_W = 44;

  localparam logic [TWO_PI_W-1:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [QEST_W-1:0] RED_RECIP =
    QEST_W'((64'd1 << (RED_SHIFT + WIDEN_SH)) / 64'(TWO_PI_Q30));
  localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(64'd1 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(64'd1 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SUM_NEG_ONE = -SUM_ONE;
  localparam logic signed [COS_W-1:0] COS_ONE = COS_W'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic signed [SUM_W-1:0] sum;
    logic [X2_W-1:0]         x2;
  } term_t;

  function automatic logic signed [SUM_W-1:0] signed_term(input logic neg,
                                                          input logic [MAG_W-1:0] mag);
    logic signed [SUM_W-1:0] ext;
    ext = $signed({{(SUM_W-MAG_W){1'b0}}, mag});
    return neg ? -ext : ext;
  endfunction

endpackage

[src/cts_stream_if.sv]
// Valid/ready channel interfaces for angle beats and cosine beats.
interface cts_angle_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cts_pkg::ANGLE_W-1:0]    angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface cts_cosine_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cts_pkg::COS_W-1:0]      cosine_value;

  modport source (output valid, output cosine_value, input ready);
  modport sink (input valid, input cosine_value, output ready);
endinterface

[src/cts_reduce.sv]
// Range reduction by two pi and squaring of the reduced angle, six stages.
module cts_reduce (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [cts_pkg::ANGLE_W-1:0]   in_angle,
  output cts_pkg::term_t                       t_out
);

  localparam int QPROD_W = cts_pkg::AMAG_W + cts_pkg::QEST_W;
  localparam int XQ_W = cts_pkg::AMAG_W + cts_pkg::WIDEN_SH;
  localparam int QC_W = XQ_W + 1;
  localparam int SQH_W = cts_pkg::RMAG_W / 2;
  localparam int SQL_W = cts_pkg::RMAG_W - SQH_W;
  localparam int SQ_W = 2 * cts_pkg::RMAG_W + 1;

  logic [5:0] v_r;

  logic [cts_pkg::AMAG_W-1:0] amag_nxt, amag1_r, amag2_r;
  logic [QPROD_W-1:0]         qprod;
  logic [cts_pkg::QEST_W-1:0] qest_nxt, qest2_r;
  logic [QC_W-1:0]            qc, rem_full;
  logic [cts_pkg::REM_W-1:0]  rem3_r;
  logic [cts_pkg::RMAG_W-1:0] rmag_nxt, rmag4_r;
  logic [SQH_W-1:0]           sq_hi;
  logic [SQL_W-1:0]           sq_lo;
  logic [2*SQH_W-1:0]         hh5_r;
  logic [SQH_W+SQL_W-1:0]     hl5_r;
  logic [2*SQL_W-1:0]         ll5_r;
  logic [SQ_W-1:0]            sq;
  logic [cts_pkg::X2_W-1:0]   x2_nxt, x2_6_r;

  assign amag_nxt = in_angle[cts_pkg::ANGLE_W-1] ? cts_pkg::AMAG_W'(-in_angle)
                                                 : cts_pkg::AMAG_W'(in_angle);

  assign qprod = QPROD_W'(amag1_r) * QPROD_W'(cts_pkg::RED_RECIP);
  assign qest_nxt = qprod[cts_pkg::RED_SHIFT +: cts_pkg::QEST_W];

  assign qc = QC_W'(qest2_r) * QC_W'(cts_pkg::TWO_PI_Q30);
  assign rem_full = QC_W'({amag2_r, {cts_pkg::WIDEN_SH{1'b0}}}) - qc;

  assign rmag_nxt = (rem3_r >= cts_pkg::REM_W'(cts_pkg::TWO_PI_Q30))
                  ? cts_pkg::RMAG_W'(rem3_r - cts_pkg::REM_W'(cts_pkg::TWO_PI_Q30))
                  : rem3_r[cts_pkg::RMAG_W-1:0];

  assign sq_hi = rmag4_r[cts_pkg::RMAG_W-1:SQL_W];
  assign sq_lo = rmag4_r[SQL_W-1:0];

  assign sq = (SQ_W'(hh5_r) << (2 * SQL_W)) + (SQ_W'(hl5_r) << (SQL_W + 1)) + SQ_W'(ll5_r);
  assign x2_nxt = sq[cts_pkg::FRAC_BITS +: cts_pkg::X2_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amag1_r <= amag_nxt;
      amag2_r <= amag1_r;
      qest2_r <= qest_nxt;
      rem3_r  <= rem_full[cts_pkg::REM_W-1:0];
      rmag4_r <= rmag_nxt;
      hh5_r   <= (2*SQH_W)'(sq_hi) * (2*SQH_W)'(sq_hi);
      hl5_r   <= (SQH_W+SQL_W)'(sq_hi) * (SQH_W+SQL_W)'(sq_lo);
      ll5_r   <= (2*SQL_W)'(sq_lo) * (2*SQL_W)'(sq_lo);
      x2_6_r  <= x2_nxt;
    end
  end

  always_comb begin
    t_out.valid = v_r[5];
    t_out.neg   = 1'b0;
    t_out.mag   = cts_pkg::MAG_ONE;
    t_out.sum   = '0;
    t_out.x2    = x2_6_r;
  end

endmodule

[src/cts_term.sv]
// One series term: multiply by x squared, divide by (2i)(2i-1), fold in the sum.
module cts_term #(
  parameter int IDX = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cts_pkg::term_t t_in,
  output cts_pkg::term_t t_out
);

  localparam int MW = cts_pkg::MAG_W;
  localparam int HALF = MW / 2;
  localparam int XH = cts_pkg::X2_W / 2;
  localparam int DEN = (2 * IDX) * (2 * IDX - 1);
  localparam int DEN_LOG = $clog2(DEN);
  localparam int P1_W = MW + cts_pkg::X2_W;
  localparam int PW = P1_W - cts_pkg::FRAC_BITS;
  localparam int PH = PW / 2;
  localparam int DIV_SHIFT = PW + DEN_LOG;
  localparam logic [63:0] DIV_RECIP_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [PW:0] DIV_RECIP = DIV_RECIP_FULL[PW:0];
  localparam int P2_W = 2 * PW + 1;

  logic [3:0] v_r;

  logic neg_r [3];
  logic signed [cts_pkg::SUM_W-1:0] sum_r [4];
  logic [cts_pkg::X2_W-1:0]         x2_r [4];
  logic signed [cts_pkg::SUM_W-1:0] sum1_nxt;

  logic [HALF-1:0]          mh, ml;
  logic [XH-1:0]            xh, xl;
  logic [HALF+XH-1:0]       hh1_r, hl1_r, lh1_r, ll1_r;
  logic [P1_W-1:0]          full1;
  logic [PW-1:0]            prod2_nxt, prod2_r;

  logic [PW-PH-1:0]         ph;
  logic [PH-1:0]            pl;
  logic [PW-PH:0]           rh;
  logic [PH-1:0]            rl;
  logic [2*(PW-PH):0]       hh3_r;
  logic [PW:0]              lh3_r;
  logic [PW-1:0]            hl3_r;
  logic [2*PH-1:0]          ll3_r;
  logic [P2_W-1:0]          full2, quo_full;
  logic [MW-1:0]            quo_nxt, quo4_r;

  assign sum1_nxt = t_in.sum + cts_pkg::signed_term(t_in.neg, t_in.mag);

  assign mh = t_in.mag[MW-1:HALF];
  assign ml = t_in.mag[HALF-1:0];
  assign xh = t_in.x2[cts_pkg::X2_W-1:XH];
  assign xl = t_in.x2[XH-1:0];

  assign full1 = (P1_W'(hh1_r) << (HALF + XH)) + (P1_W'(hl1_r) << HALF)
               + (P1_W'(lh1_r) << XH) + P1_W'(ll1_r);
  assign prod2_nxt = full1[cts_pkg::FRAC_BITS +: PW];

  assign ph = prod2_r[PW-1:PH];
  assign pl = prod2_r[PH-1:0];
  assign rh = DIV_RECIP[PW:PH];
  assign rl = DIV_RECIP[PH-1:0];

  assign full2 = (P2_W'(hh3_r) << (2 * PH)) + (P2_W'(hl3_r) << PH)
               + (P2_W'(lh3_r) << PH) + P2_W'(ll3_r);
  assign quo_full = full2 >> DIV_SHIFT;
  assign quo_nxt = quo_full[MW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], t_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= ~t_in.neg;
      neg_r[1] <= neg_r[0];
      neg_r[2] <= neg_r[1];
      sum_r[0] <= sum1_nxt;
      sum_r[1] <= sum_r[0];
      sum_r[2] <= sum_r[1];
      sum_r[3] <= sum_r[2];
      x2_r[0]  <= t_in.x2;
      x2_r[1]  <= x2_r[0];
      x2_r[2]  <= x2_r[1];
      x2_r[3]  <= x2_r[2];
      hh1_r    <= (HALF+XH)'(mh) * (HALF+XH)'(xh);
      hl1_r    <= (HALF+XH)'(mh) * (HALF+XH)'(xl);
      lh1_r    <= (HALF+XH)'(ml) * (HALF+XH)'(xh);
      ll1_r    <= (HALF+XH)'(ml) * (HALF+XH)'(xl);
      prod2_r  <= prod2_nxt;
      hh3_r    <= (2*(PW-PH)+1)'(ph) * (2*(PW-PH)+1)'(rh);
      lh3_r    <= (PW+1)'(pl) * (PW+1)'(rh);
      hl3_r    <= PW'(ph) * PW'(rl);
      ll3_r    <= (2*PH)'(pl) * (2*PH)'(rl);
      quo4_r   <= quo_nxt;
    end
  end

  logic neg4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg4_r <= neg_r[2];
    end
  end

  always_comb begin
    t_out.valid = v_r[3];
    t_out.neg   = neg4_r;
    t_out.mag   = quo4_r;
    t_out.sum   = sum_r[3];
    t_out.x2    = x2_r[3];
  end

endmodule

[src/cosine_taylor_series.sv]
// Fixed-point cosine: two pi range reduction followed by a pipelined Taylor series.
// One angle beat (signed Q16.16 radians) is taken per clock and one cosine beat
// (signed Q2.30, clamped to plus or minus one) leaves per clock, in order, while the
// output is not stalled. Six stages reduce and square the angle, each series term
// owns four stages (two for the product with x squared, two for the reciprocal
// divide by (2i)(2i-1)), and two stages close the sum and clamp. A stalled result
// freezes the whole pipeline; a one-beat input buffer keeps the input ready a
// registered signal.
module cosine_taylor_series #(
  parameter int TERMS = cts_pkg::TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  cts_angle_if.sink           in_chan,
  cts_cosine_if.source        out_chan
);

  logic                                  adv;
  logic                                  skid_full_r, skid_full_nxt;
  logic signed [cts_pkg::ANGLE_W-1:0]    skid_angle_r;
  logic                                  s0_valid;
  logic signed [cts_pkg::ANGLE_W-1:0]    s0_angle;

  cts_pkg::term_t chain [TERMS];
  cts_pkg::term_t last;

  logic                                  fin_valid_r;
  logic signed [cts_pkg::SUM_W-1:0]      fin_sum_r;
  logic                                  out_valid_r;
  logic signed [cts_pkg::COS_W-1:0]      cos_nxt, cos_r;

  assign adv = ~out_valid_r | out_chan.ready;

  assign in_chan.ready = ~skid_full_r;
  assign s0_valid = skid_full_r | in_chan.valid;
  assign s0_angle = skid_full_r ? skid_angle_r : in_chan.angle;

  always_comb begin
    skid_full_nxt = skid_full_r;
    if (adv) begin
      skid_full_nxt = 1'b0;
    end else if (in_chan.valid && !skid_full_r) begin
      skid_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_angle_r <= in_chan.angle;
    end
  end

  cts_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s0_valid),
    .in_angle (s0_angle),
    .t_out    (chain[0])
  );

  for (genvar g = 1; g < TERMS; g++) begin : g_term
    cts_term #(
      .IDX (g)
    ) u_term (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .t_in  (chain[g-1]),
      .t_out (chain[g])
    );
  end

  assign last = chain[TERMS-1];

  always_comb begin
    if (fin_sum_r > cts_pkg::SUM_ONE) begin
      cos_nxt = cts_pkg::COS_ONE;
    end else if (fin_sum_r < cts_pkg::SUM_NEG_ONE) begin
      cos_nxt = -cts_pkg::COS_ONE;
    end else begin
      cos_nxt = fin_sum_r[cts_pkg::COS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fin_valid_r <= last.valid;
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_sum_r <= last.sum + cts_pkg::signed_term(last.neg, last.mag);
      cos_r     <= cos_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.cosine_value = cos_r;

`ifndef SYNTHESIS
  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cos_r <= cts_pkg::COS_ONE) && (cos_r >= -cts_pkg::COS_ONE))
    else $error("cosine beat outside plus or minus one");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && !adv |=> skid_full_r)
    else $error("buffered angle beat dropped during stall");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> !$past(adv))
    else $error("input buffer filled while pipeline advanced");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(fin_sum_r) && $stable(fin_valid_r))
    else $error("pipeline moved during stall");
`endif

endmodule
